[sv/merge_sort_engine_unit_macros.svh]
// Assertion macros used by the merge sort engine top level.
`ifndef MERGE_SORT_ENGINE_UNIT_MACROS_SVH
`define MERGE_SORT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MSE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge sort engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge sort engine: next-cycle check failed");

`endif

[sv/mse_pkg.sv]
// Shared constants and types of the merge sort engine.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    // How the back end handles a queued request.
    typedef enum logic {
        K_STORE,
        K_DROP
    } t_kind;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_kind                    kind;
        logic                     last;
    } t_req;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_MERGE,
        ST_EMIT_ADDR,
        ST_EMIT_PUT
    } t_state;

    typedef struct packed {
        t_state state;
        logic   ovf;
    } t_back_status;

endpackage

[sv/merge_sort_engine_unit.sv]
// Top level of the merge sort engine: front end, request queue and back end.
// Operation: a list of n values is loaded at one per cycle while the queue holds
// requests, sorted in ceil(log2 n) merge passes, and emitted one value at a time
// through the emit address and put states. The merge passes run over the
// single-write ping-pong stores; a new list loads only after the last is emitted.
// Reset is synchronous and active low; it empties the queue and clears counts.
`timescale 1ns / 1ps
`include "merge_sort_engine_unit_macros.svh"

module merge_sort_engine_unit #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [mse_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_is_last,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [mse_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                               o_last_out,
    output logic                               o_overflow
);

    import mse_pkg::*;

    logic         push, q_full, q_valid, q_pop;
    t_req         push_req, q_req;
    t_back_status status;

    mse_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_value    (i_value),
        .i_is_last  (i_is_last),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_req      (push_req)
    );

    mse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_req)
    );

    mse_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_req),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow),
        .o_status       (status)
    );

    // The back end only pops requests that the queue holds.
    `MSE_ASSERT_IMPLIES(a_pop_has_data, i_clk, i_rst_n, q_pop, q_valid)
    // While loading, any result still waiting must close the previous list.
    `MSE_ASSERT_IMPLIES(a_load_after_last, i_clk, i_rst_n,
        (status.state == ST_LOAD) && o_out_valid, o_last_out)
    // The overflow flag of a pending result matches the list being emitted.
    `MSE_ASSERT_IMPLIES(a_ovf_steady, i_clk, i_rst_n,
        o_out_valid && !o_last_out, status.ovf == o_overflow)
    // A stalled result stays in place until it is taken.
    `MSE_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_sorted_value) && $stable(o_last_out))

endmodule

[sv/mse_ram.sv]
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

[sv/mse_front.sv]
// Front end: accepts input requests and tags each as stored or dropped.
`timescale 1ns / 1ps

module mse_front #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic signed [mse_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_is_last,
    input  logic                               i_q_full,
    output logic                               o_in_stall,
    output logic                               o_push,
    output mse_pkg::t_req                      o_req
);

    import mse_pkg::*;

    localparam int POS_W = $clog2(MAX_ITEMS + 1);

    logic [POS_W-1:0] r_fcount;
    logic [POS_W-1:0] n_fcount;
    logic             full_list;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign full_list  = (r_fcount == POS_W'(MAX_ITEMS));

    // Classify the request against the room left in the list.
    always_comb begin
        o_req.value = i_value;
        o_req.kind  = full_list ? K_DROP : K_STORE;
        o_req.last  = i_is_last;
        n_fcount    = r_fcount;
        if (o_push) begin
            if (i_is_last) begin
                n_fcount = '0;
            end else if (!full_list) begin
                n_fcount = r_fcount + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= '0;
        end else begin
            r_fcount <= n_fcount;
        end
    end

endmodule

[sv/mse_queue.sv]
// Short request queue between the front and back ends.
`timescale 1ns / 1ps

module mse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mse_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mse_pkg::t_req o_data
);

    import mse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_entry[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr] <= i_data;
        end
    end

endmodule

[sv/mse_back.sv]
// Back end: loads the list, runs bottom-up merge passes and emits the result.
`timescale 1ns / 1ps

module mse_back #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  mse_pkg::t_req                      i_q_data,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [mse_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                               o_last_out,
    output logic                               o_overflow,
    output mse_pkg::t_back_status              o_status
);

    import mse_pkg::*;

    localparam int POS_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int W_W    = POS_W + 1;
    localparam int SUM_W  = POS_W + 2;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_src_b, n_src_b;
    logic [W_W-1:0]   r_w, n_w;
    logic [POS_W-1:0] r_a, n_a, r_b, n_b, r_mid, n_mid, r_hi, n_hi, r_k, n_k;

    logic              we_load, we_merge;
    logic [ADDR_W-1:0] waddr, raddr0, raddr1;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [DATA_W-1:0] da, db;
    logic              a_ok, b_ok, take_a;
    logic [SUM_W-1:0]  lo_base, mid_sum, hi_sum, n_ext;
    logic [POS_W-1:0]  mid_c, hi_c, k_inc;
    logic              out_free, out_load;

    // Two ping-pong stores; the load always fills store A.
    mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store_a (
        .i_clk    (i_clk),
        .i_we     (we_load || (we_merge && r_src_b)),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store_b (
        .i_clk    (i_clk),
        .i_we     (we_merge && !r_src_b),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    assign da = r_src_b ? b_rd0 : a_rd0;
    assign db = r_src_b ? b_rd1 : a_rd1;

    // Bounds of the next run pair, clipped to the list length.
    assign lo_base = (r_state == ST_SETUP) ? '0 : SUM_W'(r_hi);
    assign mid_sum = lo_base + SUM_W'(r_w);
    assign hi_sum  = lo_base + SUM_W'({r_w, 1'b0});
    assign n_ext   = SUM_W'(r_count);
    assign mid_c   = (mid_sum > n_ext) ? r_count : mid_sum[POS_W-1:0];
    assign hi_c    = (hi_sum > n_ext) ? r_count : hi_sum[POS_W-1:0];

    // Merge choice: the left run wins ties.
    assign a_ok   = (r_a < r_mid);
    assign b_ok   = (r_b < r_hi);
    assign take_a = a_ok && (!b_ok || ($signed(da) <= $signed(db)));
    assign k_inc  = r_k + POS_W'(1);

    assign out_free = !o_out_valid || !i_out_stall;

    // Sequencer: next state, store ports, queue pop and output load.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_src_b  = r_src_b;
        n_w      = r_w;
        n_a      = r_a;
        n_b      = r_b;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_k      = r_k;
        we_load  = 1'b0;
        we_merge = 1'b0;
        waddr    = r_k[ADDR_W-1:0];
        wdata    = take_a ? da : db;
        raddr0   = r_a[ADDR_W-1:0];
        raddr1   = r_b[ADDR_W-1:0];
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.kind == K_STORE) begin
                        we_load = 1'b1;
                        waddr   = r_count[ADDR_W-1:0];
                        wdata   = i_q_data.value;
                        n_count = r_count + POS_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_q_data.last) begin
                        n_w   = W_W'(1);
                        n_k   = '0;
                        n_src_b = 1'b0;
                        n_state = (n_count <= POS_W'(1)) ? ST_EMIT_ADDR : ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_a     = '0;
                n_b     = mid_c;
                n_mid   = mid_c;
                n_hi    = hi_c;
                n_k     = '0;
                raddr0  = '0;
                raddr1  = mid_c[ADDR_W-1:0];
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                we_merge = 1'b1;
                if (k_inc == r_hi) begin
                    if (r_hi == r_count) begin
                        // Pass done: double the run width and swap stores.
                        n_w     = {r_w[W_W-2:0], 1'b0};
                        n_src_b = !r_src_b;
                        n_k     = '0;
                        n_state = (n_w >= W_W'(r_count)) ? ST_EMIT_ADDR : ST_SETUP;
                    end else begin
                        n_a    = r_hi;
                        n_b    = mid_c;
                        n_mid  = mid_c;
                        n_hi   = hi_c;
                        n_k    = k_inc;
                        raddr0 = r_hi[ADDR_W-1:0];
                        raddr1 = mid_c[ADDR_W-1:0];
                    end
                end else begin
                    n_a    = take_a ? r_a + POS_W'(1) : r_a;
                    n_b    = take_a ? r_b : r_b + POS_W'(1);
                    n_k    = k_inc;
                    raddr0 = n_a[ADDR_W-1:0];
                    raddr1 = n_b[ADDR_W-1:0];
                end
            end
            ST_EMIT_ADDR: begin
                raddr0  = r_k[ADDR_W-1:0];
                n_state = ST_EMIT_PUT;
            end
            ST_EMIT_PUT: begin
                raddr0 = r_k[ADDR_W-1:0];
                if (out_free) begin
                    out_load = 1'b1;
                    if (k_inc == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_src_b = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = k_inc;
                        n_state = ST_EMIT_ADDR;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_src_b     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_src_b <= n_src_b;
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Merge cursors and the output register.
    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_a   <= n_a;
        r_b   <= n_b;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_k   <= n_k;
        if (out_load) begin
            o_sorted_value <= $signed(da);
            o_last_out     <= (k_inc == r_count);
            o_overflow     <= r_ovf;
        end
    end

    assign o_status.state = r_state;
    assign o_status.ovf   = r_ovf;

endmodule
